// File: src/segment_allocator_fit_policy_top_assert.svh
// assertion macros for the segment allocator
`ifndef SEGMENT_ALLOCATOR_FIT_POLICY_TOP_ASSERT_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICY_TOP_ASSERT_SVH

// same-cycle implication
`define SAFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/safp_pkg.sv
// shared types and constants for the segment allocator
package safp_pkg;

    localparam logic [15:0] RESET_TOTAL = 16'd1000;
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_TOTAL_SIZE = 1'b0;

    localparam logic [1:0] ACT_INIT    = 2'd0;
    localparam logic [1:0] ACT_ALLOC   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [4:0] {
        S_BOOT,
        S_IDLE,
        S_RD,
        S_FIT,
        S_CMP,
        S_PICKED,
        S_SHR,
        S_SHW,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_FREE,
        S_NXT_CHK,
        S_DRP_RD,
        S_DRP_WR,
        S_PRV_RD,
        S_PRV_CHK,
        S_DONE
    } t_state;

endpackage

// File: src/safp_alu.sv
// shared add/subtract unit with borrow used for the segment size compares
module safp_alu
    import safp_pkg::*;
#(
    parameter int unsigned AW = 16
) (
    input  t_alu_op       i_op,
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    output logic [AW-1:0] o_res,
    output logic          o_borrow
);

    logic          sub;
    logic [AW-1:0] b_eff;
    logic [AW:0]   sum;

    assign sub      = (i_op == ALU_SUB);
    assign b_eff    = sub ? ~i_b : i_b;
    assign sum      = {1'b0, i_a} + {1'b0, b_eff} + {{AW{1'b0}}, sub};
    assign o_res    = sum[AW-1:0];
    assign o_borrow = sub & ~sum[AW];

endmodule

// File: src/safp_table.sv
// segment table memory, one write port and one registered read port
module safp_table
    import safp_pkg::*;
#(
    parameter int unsigned NUM = 32,
    parameter int unsigned WW  = 40,
    localparam int unsigned IW = $clog2(NUM)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [WW-1:0] i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [WW-1:0] o_rdata
);

    logic [WW-1:0] r_mem [NUM];
    logic [WW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/segment_allocator_fit_policy_top.sv
// segment allocator top: config register, request sequencer, result register
// one request at a time; ready only when the sequencer is idle
// init rewrites the table as one free segment; allocate/release scan the table one segment
// at a time, best/worst fit with an extra compare step, and splits or merges move table entries
// through the single table read port and the shared add/subtract unit
// synchronous reset; a boot pass then writes the initial free segment
`include "segment_allocator_fit_policy_top_assert.svh"
module segment_allocator_fit_policy_top
    import safp_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 32,
    parameter int unsigned ADDR_WIDTH   = 16,
    parameter int unsigned OWNER_WIDTH  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_action,
    input  logic [1:0]             i_fit_policy,
    input  logic [ADDR_WIDTH-1:0]  i_request_size,
    input  logic [OWNER_WIDTH-1:0] i_owner_id,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_success,
    output logic [1:0]             o_status,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int unsigned AW = ADDR_WIDTH;
    localparam int unsigned OW = OWNER_WIDTH;
    localparam int unsigned WW = 2 * AW + OW;
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

    t_state         r_state, n_state;
    logic [15:0]    r_total_size;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_k, n_k;
    logic [CW-1:0]  r_t, n_t;
    logic [1:0]     r_action, n_action;
    logic [1:0]     r_policy, n_policy;
    logic [AW-1:0]  r_size, n_size;
    logic [OW-1:0]  r_owner, n_owner;
    logic           r_found, n_found;
    logic [IW-1:0]  r_pick, n_pick;
    logic [AW-1:0]  r_pick_start, n_pick_start;
    logic [AW-1:0]  r_pick_len, n_pick_len;
    logic [AW-1:0]  r_pick_rem, n_pick_rem;
    logic [AW-1:0]  r_fit_rem, n_fit_rem;
    logic [1:0]     r_status, n_status;
    logic           r_phase, n_phase;
    logic           r_out_valid, n_out_valid;
    logic           r_out_success, n_out_success;
    logic [1:0]     r_out_status, n_out_status;

    logic           we;
    logic [IW-1:0]  waddr;
    logic [WW-1:0]  wdata;
    logic [IW-1:0]  rd_addr;
    logic [WW-1:0]  rd_word;
    logic [AW-1:0]  rd_start;
    logic [AW-1:0]  rd_len;
    logic [OW-1:0]  rd_owner;
    t_alu_op        alu_op;
    logic [AW-1:0]  alu_a;
    logic [AW-1:0]  alu_b;
    logic [AW-1:0]  alu_res;
    logic           alu_borrow;
    logic [CW-1:0]  t_m1;
    logic [CW-1:0]  t_p1;
    logic [IW-1:0]  pick_p1;
    logic [IW-1:0]  pick_m1;
    logic           in_accept;
    logic           multi_pass;
    logic           count_ok;
    logic           no_load;

    safp_table #(
        .NUM (MAX_SEGMENTS),
        .WW  (WW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_word)
    );

    safp_alu #(
        .AW (AW)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    assign rd_start = rd_word[WW-1 -: AW];
    assign rd_len   = rd_word[AW+OW-1 -: AW];
    assign rd_owner = rd_word[OW-1:0];

    assign t_m1       = r_t - CW'(1);
    assign t_p1       = r_t + CW'(1);
    assign pick_p1    = r_pick + IW'(1);
    assign pick_m1    = r_pick - IW'(1);
    assign in_accept  = i_in_valid & o_in_ready;
    assign multi_pass = (r_policy == POL_BEST) || (r_policy == POL_WORST);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_success   = r_out_success;
    assign o_status    = r_out_status;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_TOTAL_SIZE) ? {16'd0, r_total_size} : 32'd0;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_size <= RESET_TOTAL;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL_SIZE)) begin
            r_total_size <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_count     <= CW'(1);
            r_found     <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_found     <= n_found;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k           <= n_k;
        r_t           <= n_t;
        r_action      <= n_action;
        r_policy      <= n_policy;
        r_size        <= n_size;
        r_owner       <= n_owner;
        r_pick        <= n_pick;
        r_pick_start  <= n_pick_start;
        r_pick_len    <= n_pick_len;
        r_pick_rem    <= n_pick_rem;
        r_fit_rem     <= n_fit_rem;
        r_status      <= n_status;
        r_out_success <= n_out_success;
        r_out_status  <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_k           = r_k;
        n_t           = r_t;
        n_action      = r_action;
        n_policy      = r_policy;
        n_size        = r_size;
        n_owner       = r_owner;
        n_found       = r_found;
        n_pick        = r_pick;
        n_pick_start  = r_pick_start;
        n_pick_len    = r_pick_len;
        n_pick_rem    = r_pick_rem;
        n_fit_rem     = r_fit_rem;
        n_status      = r_status;
        n_phase       = r_phase;
        n_out_valid   = r_out_valid;
        n_out_success = r_out_success;
        n_out_status  = r_out_status;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        rd_addr       = r_k[IW-1:0];
        alu_op        = ALU_SUB;
        alu_a         = rd_len;
        alu_b         = r_size;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_BOOT: begin
                we      = 1'b1;
                wdata   = {{AW{1'b0}}, AW'(RESET_TOTAL), {OW{1'b0}}};
                n_count = CW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_action = i_action;
                    n_policy = i_fit_policy;
                    n_size   = i_request_size;
                    n_owner  = i_owner_id;
                    n_k      = '0;
                    n_found  = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_action)
                        ACT_INIT: begin
                            we       = 1'b1;
                            wdata    = {{AW{1'b0}}, AW'(r_total_size), {OW{1'b0}}};
                            n_count  = CW'(1);
                            n_status = STAT_OK;
                        end
                        ACT_ALLOC: begin
                            if (i_owner_id == '0) begin
                                n_status = STAT_INVALID;
                            end else if (i_request_size == '0) begin
                                n_status = STAT_NOFIT;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        ACT_RELEASE: begin
                            if (i_owner_id == '0) begin
                                n_status = STAT_INVALID;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_status = STAT_INVALID;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = (r_k >= r_count) ? S_PICKED : S_FIT;
            end
            S_FIT: begin
                n_fit_rem = alu_res;
                if (r_action == ACT_RELEASE) begin
                    if (rd_owner == r_owner) begin
                        n_found      = 1'b1;
                        n_pick       = r_k[IW-1:0];
                        n_pick_start = rd_start;
                        n_pick_len   = rd_len;
                        n_state      = S_PICKED;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_RD;
                    end
                end else if ((rd_owner != '0) || alu_borrow) begin
                    n_k     = r_k + CW'(1);
                    n_state = S_RD;
                end else if (!r_found) begin
                    n_found      = 1'b1;
                    n_pick       = r_k[IW-1:0];
                    n_pick_start = rd_start;
                    n_pick_len   = rd_len;
                    n_pick_rem   = alu_res;
                    if (multi_pass) begin
                        n_k     = r_k + CW'(1);
                        n_state = S_RD;
                    end else begin
                        n_state = S_PICKED;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_policy == POL_BEST) begin
                    alu_a = rd_len;
                    alu_b = r_pick_len;
                end else begin
                    alu_a = r_pick_len;
                    alu_b = rd_len;
                end
                if (alu_borrow) begin
                    n_pick       = r_k[IW-1:0];
                    n_pick_start = rd_start;
                    n_pick_len   = rd_len;
                    n_pick_rem   = r_fit_rem;
                end
                n_k     = r_k + CW'(1);
                n_state = S_RD;
            end
            S_PICKED: begin
                n_state = S_DONE;
                if (!r_found) begin
                    n_status = (r_action == ACT_RELEASE) ? STAT_INVALID : STAT_NOFIT;
                end else if (r_action == ACT_RELEASE) begin
                    n_state = S_FREE;
                end else if (r_pick_rem == '0) begin
                    we       = 1'b1;
                    waddr    = r_pick;
                    wdata    = {r_pick_start, r_pick_len, r_owner};
                    n_status = STAT_OK;
                end else if (r_count == CW'(MAX_SEGMENTS)) begin
                    n_status = STAT_FULL;
                end else begin
                    n_t     = r_count;
                    n_state = S_SHR;
                end
            end
            S_SHR: begin
                rd_addr = t_m1[IW-1:0];
                if (r_t > (CW'(r_pick) + CW'(1))) begin
                    n_state = S_SHW;
                end else begin
                    n_state = S_SPLIT_HI;
                end
            end
            S_SHW: begin
                rd_addr = t_m1[IW-1:0];
                we      = 1'b1;
                waddr   = r_t[IW-1:0];
                wdata   = rd_word;
                n_t     = t_m1;
                n_state = S_SHR;
            end
            S_SPLIT_HI: begin
                alu_op  = ALU_ADD;
                alu_a   = r_pick_start;
                alu_b   = r_size;
                we      = 1'b1;
                waddr   = pick_p1;
                wdata   = {alu_res, r_pick_rem, {OW{1'b0}}};
                n_state = S_SPLIT_LO;
            end
            S_SPLIT_LO: begin
                we       = 1'b1;
                waddr    = r_pick;
                wdata    = {r_pick_start, r_size, r_owner};
                n_count  = r_count + CW'(1);
                n_status = STAT_OK;
                n_state  = S_DONE;
            end
            S_FREE: begin
                we      = 1'b1;
                waddr   = r_pick;
                wdata   = {r_pick_start, r_pick_len, {OW{1'b0}}};
                rd_addr = pick_p1;
                if ((CW'(r_pick) + CW'(1)) < r_count) begin
                    n_state = S_NXT_CHK;
                end else begin
                    n_state = S_PRV_RD;
                end
            end
            S_NXT_CHK: begin
                rd_addr = pick_p1;
                alu_op  = ALU_ADD;
                alu_a   = r_pick_len;
                alu_b   = rd_len;
                if (rd_owner == '0) begin
                    we         = 1'b1;
                    waddr      = r_pick;
                    wdata      = {r_pick_start, alu_res, {OW{1'b0}}};
                    n_pick_len = alu_res;
                    n_t        = CW'(r_pick) + CW'(1);
                    n_phase    = 1'b0;
                    n_state    = S_DRP_RD;
                end else begin
                    n_state = S_PRV_RD;
                end
            end
            S_DRP_RD: begin
                rd_addr = t_p1[IW-1:0];
                if (t_p1 < r_count) begin
                    n_state = S_DRP_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    if (r_phase) begin
                        n_status = STAT_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_PRV_RD;
                    end
                end
            end
            S_DRP_WR: begin
                rd_addr = t_p1[IW-1:0];
                we      = 1'b1;
                waddr   = r_t[IW-1:0];
                wdata   = rd_word;
                n_t     = t_p1;
                n_state = S_DRP_RD;
            end
            S_PRV_RD: begin
                rd_addr = pick_m1;
                if (r_pick != '0) begin
                    n_state = S_PRV_CHK;
                end else begin
                    n_status = STAT_OK;
                    n_state  = S_DONE;
                end
            end
            S_PRV_CHK: begin
                rd_addr = pick_m1;
                alu_op  = ALU_ADD;
                alu_a   = rd_len;
                alu_b   = r_pick_len;
                if (rd_owner == '0) begin
                    we      = 1'b1;
                    waddr   = pick_m1;
                    wdata   = {rd_start, alu_res, {OW{1'b0}}};
                    n_t     = CW'(r_pick);
                    n_phase = 1'b1;
                    n_state = S_DRP_RD;
                end else begin
                    n_status = STAT_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_success = (r_status == STAT_OK);
                    n_out_status  = r_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign count_ok = (r_count != '0) && (r_count <= CW'(MAX_SEGMENTS));
    assign no_load  = !r_out_valid && (r_state != S_DONE);

    `SAFP_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, count_ok, "segment count out of range")
    `SAFP_ASSERT_NEXT(a_busy, i_clk, i_rst_n, in_accept, !o_in_ready, "ready after accept")
    `SAFP_ASSERT_NEXT(a_load_in_done, i_clk, i_rst_n, no_load, !r_out_valid, "result outside done")

endmodule
